>>> hw/rtl/rdr_pkg.sv
// ----------------------------------------------------------------------------
// rdr_pkg
// Shared constants, codes and types of the datagram reorder receiver.
// ----------------------------------------------------------------------------
package rdr_pkg;

  localparam int DEF_SLOTS      = 5;
  localparam int DEF_SLOT_BYTES = 1024;
  localparam int MAX_RES        = 6;
  localparam int SLOT_IDX_W     = 3;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 32;

  localparam logic [15:0] WINDOW_RST = 16'd5120;
  localparam logic [3:0]  RETRY_RST  = 4'd5;
  localparam logic [3:0]  TCNT_MAX   = 4'd15;

  // opcodes
  localparam logic [2:0] OP_SYN   = 3'd0;
  localparam logic [2:0] OP_DAT   = 3'd1;
  localparam logic [2:0] OP_FIN   = 3'd2;
  localparam logic [2:0] OP_OTHER = 3'd3;
  localparam logic [2:0] OP_TICK  = 3'd4;

  // deliver codes
  localparam logic [1:0] DLV_NONE = 2'd0;
  localparam logic [1:0] DLV_CUR  = 2'd1;
  localparam logic [1:0] DLV_SLOT = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_REFUSED  = 2'd1;
  localparam logic [1:0] ST_FINISHED = 2'd2;
  localparam logic [1:0] ST_LOST     = 2'd3;

  // register indexes
  localparam logic REG_WINDOW = 1'b0;
  localparam logic REG_RETRY  = 1'b1;

  typedef enum logic [2:0] {
    STEP_NONE,
    STEP_HEAD,
    STEP_DRAIN,
    STEP_TAIL,
    STEP_FLUSH
  } step_t;

  typedef struct packed {
    logic                  load;
    logic                  go;
    step_t                 step;
    logic [SLOT_IDX_W-1:0] slot_idx;
  } rdr_cmd_t;

  typedef struct packed {
    logic busy;
    logic drain_en;
  } rdr_stat_t;

  typedef struct packed {
    logic [31:0] ack_number;
    logic [15:0] window_adv;
    logic        send_ack;
    logic [1:0]  deliver;
    logic [2:0]  deliver_slot;
    logic [1:0]  status;
    logic        last;
  } rdr_res_t;

  typedef struct packed {
    logic [15:0] window_bytes;
    logic [3:0]  retry_limit;
  } rdr_cfg_t;

endpackage

>>> hw/rtl/rdr_ifs.sv
// ----------------------------------------------------------------------------
// rdr channel interfaces
// Valid/ready channels for packet events in and acknowledgement results out.
// ----------------------------------------------------------------------------
interface rdr_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [31:0] seq_num;
  logic [9:0]  pkt_len;

  modport source (output valid, output opcode, output seq_num, output pkt_len,
                  input ready);
  modport sink (input valid, input opcode, input seq_num, input pkt_len,
                output ready);
endinterface

interface rdr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] ack_number;
  logic [15:0] window_adv;
  logic        send_ack;
  logic [1:0]  deliver;
  logic [2:0]  deliver_slot;
  logic [1:0]  status;
  logic        last;

  modport source (output valid, output ack_number, output window_adv,
                  output send_ack, output deliver, output deliver_slot,
                  output status, output last, input ready);
  modport sink (input valid, input ack_number, input window_adv,
                input send_ack, input deliver, input deliver_slot,
                input status, input last, output ready);
endinterface

>>> hw/rtl/rdr_regs.sv
// ----------------------------------------------------------------------------
// rdr_regs
// APB-style configuration registers: receive window and retry limit.
// ----------------------------------------------------------------------------
module rdr_regs
  import rdr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output rdr_cfg_t              cfg
);

  logic [15:0] window_r;
  logic [3:0]  retry_r;
  logic        wr_en;
  logic        reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RST;
      retry_r  <= RETRY_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_WINDOW: window_r <= pwdata[15:0];
        REG_RETRY:  retry_r  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_WINDOW: prdata = {{(CFG_DATA_W-16){1'b0}}, window_r};
      REG_RETRY:  prdata = {{(CFG_DATA_W-4){1'b0}}, retry_r};
      default:    prdata = '0;
    endcase
  end

  assign cfg.window_bytes = window_r;
  assign cfg.retry_limit  = retry_r;

endmodule

>>> hw/rtl/rdr_ctrl.sv
// ----------------------------------------------------------------------------
// rdr_ctrl
// Sequencer: header step; if enabled, one drain step per slot and tail; flush.
// ----------------------------------------------------------------------------
module rdr_ctrl
  import rdr_pkg::*;
#(
  parameter int SLOTS = DEF_SLOTS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  rdr_stat_t stat,
  output rdr_cmd_t  cmd
);

  localparam int SIW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD,
    S_DRAIN,
    S_TAIL,
    S_FLUSH
  } state_t;

  state_t         state_r, state_nxt;
  logic [SIW-1:0] idx_r, idx_nxt;
  logic           ready_r, ready_nxt;
  logic           go;

  assign go = !stat.busy;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    case (state_r)
      S_IDLE: if (in_valid && ready_r) state_nxt = S_HEAD;
      S_HEAD: begin
        if (go) begin
          idx_nxt   = '0;
          state_nxt = stat.drain_en ? S_DRAIN : S_FLUSH;
        end
      end
      S_DRAIN: begin
        if (go) begin
          if (idx_r == SIW'(SLOTS - 1)) state_nxt = S_TAIL;
          else                          idx_nxt   = idx_r + 1'b1;
        end
      end
      S_TAIL:  if (go) state_nxt = S_FLUSH;
      S_FLUSH: if (go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    ready_nxt = (state_nxt == S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      ready_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      ready_r <= ready_nxt;
    end
  end

  always_comb begin
    cmd.load     = in_valid && ready_r;
    cmd.slot_idx = SLOT_IDX_W'(idx_r);
    case (state_r)
      S_HEAD:  cmd.step = STEP_HEAD;
      S_DRAIN: cmd.step = STEP_DRAIN;
      S_TAIL:  cmd.step = STEP_TAIL;
      S_FLUSH: cmd.step = STEP_FLUSH;
      default: cmd.step = STEP_NONE;
    endcase
    cmd.go = go && (state_r != S_IDLE);
  end

  assign in_ready = ready_r;

endmodule

>>> hw/rtl/rdr_dp.sv
// ----------------------------------------------------------------------------
// rdr_dp
// Session state, reorder slots, window calculation and result staging.
// ----------------------------------------------------------------------------
module rdr_dp
  import rdr_pkg::*;
#(
  parameter int SLOTS      = DEF_SLOTS,
  parameter int SLOT_BYTES = DEF_SLOT_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  rdr_cfg_t    cfg,
  input  rdr_cmd_t    cmd,
  output rdr_stat_t   stat,
  input  logic [2:0]  in_opcode,
  input  logic [31:0] in_seq_num,
  input  logic [9:0]  in_pkt_len,
  output logic        out_valid,
  input  logic        out_ready,
  output rdr_res_t    out_res
);

  localparam int SIW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNTW = $clog2(SLOTS + 1);
  localparam int UW   = $clog2(SLOTS * SLOT_BYTES + 1);
  localparam int CW   = (UW > 16) ? UW : 16;

  // latched item
  logic [2:0]  op_r;
  logic [31:0] seq_r;
  logic [9:0]  len_r;

  // session state
  logic [31:0] exp_r, exp_nxt;
  logic        conn_r, conn_nxt;
  logic        fin_r, fin_nxt;
  logic [3:0]  tc_r, tc_nxt;
  logic [SLOTS-1:0] valid_r, valid_nxt;
  logic [31:0] slot_seq_r [SLOTS];
  logic [9:0]  slot_len_r [SLOTS];

  // result staging: the newest result waits in hold until its last flag is known
  rdr_res_t hold_r, out_r, push_res, emit_res;
  logic     hold_v_r, hold_v_nxt, out_v_r;
  logic [2:0] res_cnt_r;

  logic           emit_req, emit_pre, emit_fire, flush_fire, push;
  logic           e_send;
  logic [1:0]     e_dlv, e_status;
  logic [2:0]     e_slot;
  logic           park_we, pfound, hit, lost;
  logic [SIW-1:0] pidx, si;
  logic [3:0]     tc_inc;

  logic [SLOTS-1:0] win_vec;
  logic [CNTW-1:0]  used_cnt;
  logic [CW-1:0]    used_bytes, wb_ext;
  logic [15:0]      win_val;

  assign si = cmd.slot_idx[SIW-1:0];

  // duplicate lookup and first free slot
  always_comb begin
    hit    = 1'b0;
    pfound = 1'b0;
    pidx   = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (valid_r[i] && slot_seq_r[i] == seq_r) hit = 1'b1;
      if (!valid_r[i] && !pfound) begin
        pfound = 1'b1;
        pidx   = SIW'(i);
      end
    end
  end

  assign tc_inc = (tc_r == TCNT_MAX) ? TCNT_MAX : tc_r + 4'd1;
  assign lost   = (tc_inc >= cfg.retry_limit);

  always_comb begin
    exp_nxt   = exp_r;
    conn_nxt  = conn_r;
    fin_nxt   = fin_r;
    tc_nxt    = tc_r;
    valid_nxt = valid_r;
    park_we   = 1'b0;
    emit_req  = 1'b0;
    emit_pre  = 1'b0;
    e_send    = 1'b1;
    e_dlv     = DLV_NONE;
    e_slot    = '0;
    e_status  = ST_OK;
    case (cmd.step)
      STEP_HEAD: begin
        emit_req = 1'b1;
        if (fin_r) begin
          e_send   = 1'b0;
          e_status = ST_FINISHED;
        end else if (!conn_r) begin
          if (op_r == OP_SYN) begin
            exp_nxt  = seq_r + {22'd0, len_r};
            conn_nxt = 1'b1;
            tc_nxt   = '0;
          end else begin
            e_send   = 1'b0;
            e_status = ST_REFUSED;
          end
        end else if (op_r == OP_TICK) begin
          // result reflects the session before a link-lost clear
          emit_pre = 1'b1;
          tc_nxt   = tc_inc;
          if (lost) begin
            e_status  = ST_LOST;
            conn_nxt  = 1'b0;
            exp_nxt   = '0;
            tc_nxt    = '0;
            valid_nxt = '0;
          end
        end else begin
          tc_nxt = '0;
          if (op_r == OP_DAT) begin
            if (seq_r < exp_r || hit) begin
              e_dlv = DLV_NONE;
            end else if (seq_r == exp_r) begin
              exp_nxt = exp_r + {22'd0, len_r};
              e_dlv   = DLV_CUR;
            end else if (pfound) begin
              park_we         = 1'b1;
              valid_nxt[pidx] = 1'b1;
            end
          end else begin
            emit_req = 1'b0;
          end
        end
      end
      STEP_DRAIN: begin
        if (valid_r[si]) begin
          if (slot_seq_r[si] < exp_r) begin
            valid_nxt[si] = 1'b0;
          end else if (slot_seq_r[si] == exp_r) begin
            valid_nxt[si] = 1'b0;
            exp_nxt       = exp_r + {22'd0, slot_len_r[si]};
            emit_req      = 1'b1;
            e_dlv         = DLV_SLOT;
            e_slot        = 3'(si);
          end
        end
      end
      STEP_TAIL: begin
        if (op_r == OP_SYN) begin
          exp_nxt = exp_r + {22'd0, len_r};
        end else if (op_r == OP_FIN) begin
          exp_nxt  = exp_r + {22'd0, len_r};
          fin_nxt  = 1'b1;
          emit_req = 1'b1;
          e_status = ST_FINISHED;
        end
      end
      default: ;
    endcase
  end

  // advertised window: window_bytes less one slot's bytes per used slot
  assign win_vec = emit_pre ? valid_r : valid_nxt;

  always_comb begin
    used_cnt = '0;
    for (int i = 0; i < SLOTS; i++) used_cnt = used_cnt + CNTW'(win_vec[i]);
  end

  assign used_bytes = CW'(used_cnt) * CW'(SLOT_BYTES);
  assign wb_ext     = CW'(cfg.window_bytes);
  assign win_val    = (used_bytes >= wb_ext) ? 16'd0 : 16'(wb_ext - used_bytes);

  always_comb begin
    emit_res.ack_number   = emit_pre ? exp_r : exp_nxt;
    emit_res.window_adv   = win_val;
    emit_res.send_ack     = e_send;
    emit_res.deliver      = e_dlv;
    emit_res.deliver_slot = e_slot;
    emit_res.status       = e_status;
    emit_res.last         = 1'b0;
  end

  assign emit_fire  = cmd.go && emit_req && (res_cnt_r < 3'(MAX_RES));
  assign flush_fire = cmd.go && (cmd.step == STEP_FLUSH) && hold_v_r;
  assign push       = (emit_fire && hold_v_r) || flush_fire;

  always_comb begin
    push_res      = hold_r;
    push_res.last = flush_fire;
    if (emit_fire)       hold_v_nxt = 1'b1;
    else if (flush_fire) hold_v_nxt = 1'b0;
    else                 hold_v_nxt = hold_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r     <= '0;
      conn_r    <= 1'b0;
      fin_r     <= 1'b0;
      tc_r      <= '0;
      valid_r   <= '0;
      hold_v_r  <= 1'b0;
      out_v_r   <= 1'b0;
      res_cnt_r <= '0;
    end else begin
      if (cmd.go) begin
        exp_r   <= exp_nxt;
        conn_r  <= conn_nxt;
        fin_r   <= fin_nxt;
        tc_r    <= tc_nxt;
        valid_r <= valid_nxt;
      end
      if (cmd.load)       res_cnt_r <= '0;
      else if (emit_fire) res_cnt_r <= res_cnt_r + 3'd1;
      hold_v_r <= hold_v_nxt;
      if (push)                      out_v_r <= 1'b1;
      else if (out_v_r && out_ready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_opcode;
      seq_r <= in_seq_num;
      len_r <= in_pkt_len;
    end
    if (cmd.go && park_we) begin
      slot_seq_r[pidx] <= seq_r;
      slot_len_r[pidx] <= len_r;
    end
    if (emit_fire) hold_r <= emit_res;
    if (push)      out_r  <= push_res;
  end

  assign stat.busy     = hold_v_r && out_v_r && !out_ready;
  assign stat.drain_en = conn_r && !fin_r && (op_r != OP_TICK);

  assign out_valid = out_v_r;
  assign out_res   = out_r;

endmodule

>>> hw/rtl/reliable_datagram_reorder_receiver_core.sv
// ----------------------------------------------------------------------------
// reliable_datagram_reorder_receiver_core
// Receive side of a byte-sequenced datagram session with a reorder buffer.
// ----------------------------------------------------------------------------
// Usage:
//   in_if   : one transaction per packet event (SYN, DAT, FIN, other, tick).
//   out_if  : acknowledgement / status results, zero to six per packet;
//             last marks the final result of a packet.
//   cfg_*   : APB-style writes to window_bytes (0x0) and retry_limit (0x4),
//             only while the block is idle.
// Sequence: a packet that runs the drain pass goes through the header step,
//   one drain step per reorder slot, the tail step and the flush before
//   in_if.ready returns; one that skips it (before SYN, after FIN, timeout tick)
//   goes from the header step straight to the flush. The drain sequencer visits
//   the slots one per cycle unless a stalled out_if holds it.
//   A result is held until the next one is produced or the flush step, and
//   out_if.valid rises at that edge.
// Stall: when out_if is not taken, the sequencer waits with the next result
//   in its hold register; nothing is dropped.
// Reset: synchronous, active low; the session returns to waiting for SYN,
//   all slots are freed and the registers take their default values.
// ----------------------------------------------------------------------------
module reliable_datagram_reorder_receiver_core
  import rdr_pkg::*;
#(
  parameter int SLOTS      = DEF_SLOTS,
  parameter int SLOT_BYTES = DEF_SLOT_BYTES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rdr_in_if.sink                in_if,
  rdr_out_if.source             out_if,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  rdr_cfg_t  cfg;
  rdr_cmd_t  cmd;
  rdr_stat_t stat;
  rdr_res_t  res;
  logic      in_ready;

  rdr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  rdr_ctrl #(.SLOTS(SLOTS)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rdr_dp #(.SLOTS(SLOTS), .SLOT_BYTES(SLOT_BYTES)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cmd        (cmd),
    .stat       (stat),
    .in_opcode  (in_if.opcode),
    .in_seq_num (in_if.seq_num),
    .in_pkt_len (in_if.pkt_len),
    .out_valid  (out_if.valid),
    .out_ready  (out_if.ready),
    .out_res    (res)
  );

  assign in_if.ready         = in_ready;
  assign out_if.ack_number   = res.ack_number;
  assign out_if.window_adv   = res.window_adv;
  assign out_if.send_ack     = res.send_ack;
  assign out_if.deliver      = res.deliver;
  assign out_if.deliver_slot = res.deliver_slot;
  assign out_if.status       = res.status;
  assign out_if.last         = res.last;

endmodule

>>> hw/rtl/rdr_chk.sv
// ----------------------------------------------------------------------------
// rdr_chk
// Port-level checks of the reorder receiver, bound to the top level.
// ----------------------------------------------------------------------------
module rdr_chk
  import rdr_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] ack_number,
  input logic        send_ack,
  input logic [1:0]  deliver,
  input logic [2:0]  deliver_slot,
  input logic [1:0]  status,
  input logic        last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(ack_number) && $stable(deliver)
      && $stable(status) && $stable(last))
    else $error("stalled result changed");

  // one packet at a time: ready drops after each accepted transaction
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready held after accept");

  // slot index only travels with a buffered delivery, which is a plain ACK
  a_slot_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && deliver != DLV_SLOT |-> deliver_slot == 3'd0)
    else $error("slot index without buffered delivery");

  a_slot_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && deliver == DLV_SLOT |-> send_ack && status == ST_OK)
    else $error("buffered delivery without ACK");

  // a refusal is the only result of its packet and sends nothing
  a_refused: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_REFUSED |-> !send_ack && last && deliver == DLV_NONE)
    else $error("malformed refusal");

endmodule

bind reliable_datagram_reorder_receiver_core rdr_chk u_rdr_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_if.valid),
  .in_ready     (in_if.ready),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .ack_number   (out_if.ack_number),
  .send_ack     (out_if.send_ack),
  .deliver      (out_if.deliver),
  .deliver_slot (out_if.deliver_slot),
  .status       (out_if.status),
  .last         (out_if.last)
);
